/* hw/rtl/ggaf_pkg.sv */
// ----------------------------------------------------------------------------
// ggaf_pkg
// Types and constants for the per-population allele frequency block.
// ----------------------------------------------------------------------------
package ggaf_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_PUSH
  } ggaf_state_e;

  // Half-unit accumulators
  localparam int unsigned HALF_W = 15;
  localparam logic [HALF_W-1:0] HALF_MAX = 15'h7fff;

  // Item kinds
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_ACC  = 1'b1;

  // Raw genotype codes
  localparam logic [1:0] GT_HOM_MINOR = 2'd0;
  localparam logic [1:0] GT_MISSING   = 2'd1;
  localparam logic [1:0] GT_HET       = 2'd2;
  localparam logic [1:0] GT_HOM_MAJOR = 2'd3;

  // Minor-allele dosage of a non-missing code
  function automatic logic [1:0] gt_dosage(input logic [1:0] code);
    logic [1:0] dos;
    case (code)
      GT_HOM_MINOR: dos = 2'd2;
      GT_HET:       dos = 2'd1;
      default:      dos = 2'd0;
    endcase
    return dos;
  endfunction

endpackage

/* hw/rtl/genotype_group_allele_freq.sv */
// ----------------------------------------------------------------------------
// genotype_group_allele_freq
// Per-population minor allele frequency over a stream of 2-bit genotype
// codes, with one shared restoring divider for the per-site emission.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o | kind .. last_of_site
//   out     | output    | out_valid_o / out_stall_i| population .. last
//   cfg     | input     | cfg_valid_i / cfg_ready_o| population_count
//
// A scan word at most writes a ploidy flag; an accumulate word takes a flag
// and sum memory read, then a read-modify-write. At a site's end each
// emitted population takes a memory read, a divider load, FREQ_FRAC_BITS+1
// divider steps, then the push into the output register once it is free.
// After reset a clearing pass zeroes every entry of the ploidy flag memory;
// no input word is taken meanwhile, configuration writes are.
// A stalled output holds its word while a new input word can still enter.
// ----------------------------------------------------------------------------
module genotype_group_allele_freq
  import ggaf_pkg::*;
#(
  parameter int unsigned MAX_INDIVIDUALS = 4096,
  parameter int unsigned MAX_POPULATIONS = 64,
  parameter int unsigned FREQ_FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [6:0]              cfg_population_count_i,
  // input words
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [1:0]              genotype_code_i,
  input  logic [11:0]             individual_index_i,
  input  logic [5:0]              population_index_i,
  input  logic                    last_of_site_i,
  // result words
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [5:0]              population_o,
  output logic [FREQ_FRAC_BITS:0] frequency_o,
  output logic                    present_o,
  output logic [13:0]             allele_count_o,
  output logic                    last_o
);

  localparam int unsigned IND_AW  = $clog2(MAX_INDIVIDUALS);
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned POP_AW  = (MAX_POPULATIONS > 1) ? $clog2(MAX_POPULATIONS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_POPULATIONS + 1);
  localparam int unsigned STEP_W  = $clog2(FREQ_FRAC_BITS + 2);
  localparam int unsigned Q_W     = FREQ_FRAC_BITS + 1;
  localparam logic [IND_AW-1:0] CLR_LAST  = IND_AW'(MAX_INDIVIDUALS - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FREQ_FRAC_BITS);

  ggaf_state_e state_q, state_d;

  // control from the sequencer
  logic in_acc;
  logic flag_we;
  logic flag_wdata;
  logic [IND_AW-1:0] flag_waddr;
  logic sum_we;
  logic clear_all;
  logic out_free;
  logic out_load;
  logic emit_last;

  // configuration and count
  logic [6:0] cfg_q;
  logic [CNT_W-1:0] count_eff;

  // input decode
  logic [IDX_W-1:0] ind_ext;
  logic ind_ok;
  logic [IND_AW-1:0] ind_addr;
  logic pop_ok;

  // captured accumulate word
  logic [1:0] code_q;
  logic [POP_AW-1:0] pop_q;
  logic pop_ok_q;
  logic ind_ok_q;
  logic last_q;

  // memories
  logic flag_mem [MAX_INDIVIDUALS];
  logic flag_rd_q;
  logic [2*HALF_W-1:0] half_mem [MAX_POPULATIONS];
  logic [2*HALF_W-1:0] half_rd_q;
  logic [MAX_POPULATIONS-1:0] valid_q;
  logic rd_vld_q;
  logic [POP_AW-1:0] rd_addr;

  // accumulate datapath
  logic dip;
  logic [1:0] dos;
  logic [2:0] add_sum;
  logic [2:0] add_tot;
  logic [HALF_W-1:0] old_sum, old_tot;
  logic [HALF_W:0] raw_sum, raw_tot;
  logic [HALF_W-1:0] new_sum, new_tot;

  // sequencer counters
  logic [IND_AW-1:0] clr_addr_q;
  logic [CNT_W-1:0] emit_cnt_q;

  // divider
  logic [HALF_W-1:0] tot_q;
  logic [HALF_W:0] rem_q, rem_d, cand;
  logic [Q_W-1:0] quo_q;
  logic [STEP_W-1:0] step_q;
  logic ge;

  // output register
  logic out_valid_q;
  logic [5:0] out_pop_q;
  logic [Q_W-1:0] out_freq_q;
  logic out_present_q;
  logic [13:0] out_count_q;
  logic out_last_q;

  // Decode the incoming word
  assign ind_ext  = IDX_W'(individual_index_i);
  assign ind_ok   = ind_ext < IDX_W'(MAX_INDIVIDUALS);
  assign ind_addr = ind_ext[IND_AW-1:0];
  assign pop_ok   = 7'(population_index_i) < 7'(MAX_POPULATIONS);

  // Saturate the configured count into 1..MAX_POPULATIONS
  always_comb begin
    if (cfg_q == 7'd0) begin
      count_eff = CNT_W'(1);
    end else if (cfg_q > 7'(MAX_POPULATIONS)) begin
      count_eff = CNT_W'(MAX_POPULATIONS);
    end else begin
      count_eff = CNT_W'(cfg_q);
    end
  end

  assign emit_last = (emit_cnt_q + CNT_W'(1)) == count_eff;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_addr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i && kind_i == KIND_ACC) state_d = ST_ACC;
      ST_ACC:   state_d = last_q ? ST_READ : ST_IDLE;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (step_q == STEP_LAST) state_d = ST_PUSH;
      ST_PUSH: begin
        if (out_free) state_d = emit_last ? ST_IDLE : ST_READ;
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_acc     = 1'b0;
    flag_we    = 1'b0;
    flag_wdata = 1'b0;
    flag_waddr = ind_addr;
    sum_we     = 1'b0;
    clear_all  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_addr_q;
      end
      ST_IDLE: begin
        in_acc = in_valid_i;
        if (in_valid_i && kind_i == KIND_SCAN && genotype_code_i == GT_HET && ind_ok) begin
          flag_we    = 1'b1;
          flag_wdata = 1'b1;
        end
      end
      ST_ACC: begin
        sum_we = (code_q != GT_MISSING) && pop_ok_q;
      end
      ST_PUSH: begin
        out_load  = out_free;
        clear_all = out_free && emit_last;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Hold state, configuration and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cfg_q      <= 7'd1;
      clr_addr_q <= '0;
      emit_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) cfg_q <= cfg_population_count_i;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + IND_AW'(1);
      if (out_load) emit_cnt_q <= emit_last ? '0 : emit_cnt_q + CNT_W'(1);
    end
  end

  // Capture an accumulate word
  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i == KIND_ACC) begin
      code_q   <= genotype_code_i;
      pop_q    <= population_index_i[POP_AW-1:0];
      pop_ok_q <= pop_ok;
      ind_ok_q <= ind_ok;
      last_q   <= last_of_site_i;
    end
  end

  // Ploidy flag memory
  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
    flag_rd_q <= flag_mem[ind_addr];
  end

  // Sum memory: read the emit slot in the read state, the input population otherwise
  assign rd_addr = (state_q == ST_READ) ? emit_cnt_q[POP_AW-1:0]
                                        : population_index_i[POP_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (sum_we) half_mem[pop_q] <= {new_sum, new_tot};
    half_rd_q <= half_mem[rd_addr];
  end

  // Track written entries; drop all at the end of a site
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[rd_addr];
      if (clear_all) begin
        valid_q <= '0;
      end else if (sum_we) begin
        valid_q[pop_q] <= 1'b1;
      end
    end
  end

  // Add dosage and ploidy, saturating
  assign dip     = ind_ok_q && flag_rd_q;
  assign dos     = gt_dosage(code_q);
  assign add_sum = dip ? {dos, 1'b0} : {1'b0, dos};
  assign add_tot = dip ? 3'd4 : 3'd2;
  assign old_sum = rd_vld_q ? half_rd_q[2*HALF_W-1:HALF_W] : '0;
  assign old_tot = rd_vld_q ? half_rd_q[HALF_W-1:0] : '0;
  assign raw_sum = {1'b0, old_sum} + (HALF_W+1)'(add_sum);
  assign raw_tot = {1'b0, old_tot} + (HALF_W+1)'(add_tot);
  assign new_sum = raw_sum[HALF_W] ? HALF_MAX : raw_sum[HALF_W-1:0];
  assign new_tot = raw_tot[HALF_W] ? HALF_MAX : raw_tot[HALF_W-1:0];

  // Restoring divider step: first step compares the sum, later ones shift
  assign cand  = (step_q == '0) ? rem_q : {rem_q[HALF_W-1:0], 1'b0};
  assign ge    = cand >= {1'b0, tot_q};
  assign rem_d = ge ? cand - {1'b0, tot_q} : cand;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      tot_q  <= rd_vld_q ? half_rd_q[HALF_W-1:0] : '0;
      rem_q  <= {1'b0, rd_vld_q ? half_rd_q[2*HALF_W-1:HALF_W] : HALF_W'(0)};
      quo_q  <= '0;
      step_q <= '0;
    end else if (state_q == ST_DIV) begin
      rem_q  <= rem_d;
      quo_q  <= {quo_q[Q_W-2:0], ge};
      step_q <= step_q + STEP_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pop_q     <= 6'(emit_cnt_q);
      out_present_q <= (tot_q != '0);
      out_freq_q    <= (tot_q != '0) ? quo_q : '0;
      out_count_q   <= tot_q[HALF_W-1:1];
      out_last_q    <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign population_o   = out_pop_q;
  assign frequency_o    = out_freq_q;
  assign present_o      = out_present_q;
  assign allele_count_o = out_count_q;
  assign last_o         = out_last_q;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for genotype_group_allele_freq. A scoreboard model
// tracks ploidy flags and per-population half-unit sums, and predicts every
// result word of a site's emission. Directed tests cover the register
// reset value and saturation, every genotype code, ploidy marking and
// heavy accumulation. A random test then sends well-formed sites with
// random content, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb
  import ggaf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_INDIVIDUALS = 4096;
  localparam int unsigned NUM_POPULATIONS = 64;
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned RANDOM_WORDS    = 72;
  localparam int unsigned SAT_WORDS       = 16;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [5:0]         population;
    logic [FRAC_BITS:0] frequency;
    logic               present;
    logic [13:0]        allele_count;
    logic               last;
  } freq_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [6:0]           cfg_population_count_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 kind_i;
  logic [1:0]           genotype_code_i;
  logic [11:0]          individual_index_i;
  logic [5:0]           population_index_i;
  logic                 last_of_site_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [5:0]           population_o;
  logic [FRAC_BITS:0]   frequency_o;
  logic                 present_o;
  logic [13:0]          allele_count_o;
  logic                 last_o;

  // scoreboard state
  logic                 ploidy_flag [NUM_INDIVIDUALS];
  logic [HALF_W-1:0]    dosage_half [NUM_POPULATIONS];
  logic [HALF_W-1:0]    calls_half  [NUM_POPULATIONS];
  logic [6:0]           pop_count_reg;
  freq_word_t           pending_freqs [$];

  int unsigned          mismatches;
  int unsigned          stall_left;
  bit                   quiet;

  genotype_group_allele_freq i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_population_count_i (cfg_population_count_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .kind_i                 (kind_i),
    .genotype_code_i        (genotype_code_i),
    .individual_index_i     (individual_index_i),
    .population_index_i     (population_index_i),
    .last_of_site_i         (last_of_site_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .population_o           (population_o),
    .frequency_o            (frequency_o),
    .present_o              (present_o),
    .allele_count_o         (allele_count_o),
    .last_o                 (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Pick an idle length: mostly none, often short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned emitted_populations();
    if (pop_count_reg == 0) return 1;
    if (pop_count_reg > NUM_POPULATIONS) return NUM_POPULATIONS;
    return 32'(pop_count_reg);
  endfunction

  function automatic logic [HALF_W-1:0] add_saturate(input logic [HALF_W-1:0] acc,
                                                     input int unsigned inc);
    int unsigned s;
    s = acc + inc;
    return (s > HALF_MAX) ? HALF_MAX : s[HALF_W-1:0];
  endfunction

  // Update the scoreboard with one accepted word and queue its results.
  task automatic predict_word(input logic kind, input logic [1:0] code,
                              input logic [11:0] ind, input logic [5:0] pop,
                              input logic last);
    int unsigned dosage;
    int unsigned n;
    logic [31:0] num;
    freq_word_t  w;
    if (kind == KIND_SCAN) begin
      if (code == GT_HET) ploidy_flag[ind] = 1'b1;
      return;
    end
    if (code != GT_MISSING) begin
      case (code)
        GT_HOM_MINOR: dosage = 2;
        GT_HET:       dosage = 1;
        default:      dosage = 0;
      endcase
      if (ploidy_flag[ind]) begin
        dosage_half[pop] = add_saturate(dosage_half[pop], 2 * dosage);
        calls_half[pop]  = add_saturate(calls_half[pop], 4);
      end else begin
        dosage_half[pop] = add_saturate(dosage_half[pop], dosage);
        calls_half[pop]  = add_saturate(calls_half[pop], 2);
      end
    end
    if (!last) return;
    n = emitted_populations();
    for (int p = 0; p < n; p++) begin
      w.population   = p[5:0];
      w.present      = (calls_half[p] != 0);
      num            = {17'd0, dosage_half[p]} << FRAC_BITS;
      w.frequency    = w.present ? 17'(num / calls_half[p]) : '0;
      w.allele_count = 14'(calls_half[p] >> 1);
      w.last         = (p == n - 1);
      pending_freqs.push_back(w);
    end
    for (int p = 0; p < NUM_POPULATIONS; p++) begin
      dosage_half[p] = '0;
      calls_half[p]  = '0;
    end
  endtask

  // Send one word after a random gap; valid stays high on return.
  task automatic send_word(input logic kind, input logic [1:0] code,
                           input logic [11:0] ind, input logic [5:0] pop,
                           input logic last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    kind_i             <= kind;
    genotype_code_i    <= code;
    individual_index_i <= ind;
    population_index_i <= pop;
    last_of_site_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(kind, code, ind, pop, last);
  endtask

  // Drop valid, wait for every pending result, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_freqs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_population_count(input logic [6:0] value);
    @(negedge clk_i);
    cfg_valid_i            <= 1'b1;
    cfg_population_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    pop_count_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset count of one: a site with calls, then a site with none; a
  // population above the count accumulates but is cleared unseen.
  task automatic test_reset_count();
    send_word(KIND_ACC, GT_HET,       12'd3, 6'd0, 1'b0);
    send_word(KIND_ACC, GT_HOM_MAJOR, 12'd4, 6'd0, 1'b0);
    send_word(KIND_ACC, GT_HOM_MINOR, 12'd5, 6'd5, 1'b1);
    send_word(KIND_ACC, GT_MISSING,   12'd6, 6'd0, 1'b0);
    send_word(KIND_ACC, GT_MISSING,   12'd7, 6'd5, 1'b1);
    drain();
  endtask

  // Mark diploids by scan, then accumulate every code for haploid and
  // diploid individuals at the index extremes.
  task automatic test_codes_ploidy();
    write_population_count(7'd4);
    send_word(KIND_SCAN, GT_HET,       12'd1,    6'd0,  1'b1);
    send_word(KIND_SCAN, GT_HET,       12'd4095, 6'd63, 1'b0);
    send_word(KIND_SCAN, GT_HOM_MINOR, 12'd2,    6'd0,  1'b0);
    send_word(KIND_SCAN, GT_MISSING,   12'd0,    6'd0,  1'b1);
    send_word(KIND_ACC,  GT_HOM_MINOR, 12'd1,    6'd0,  1'b0);
    send_word(KIND_ACC,  GT_HET,       12'd0,    6'd0,  1'b0);
    send_word(KIND_ACC,  GT_HET,       12'd4095, 6'd1,  1'b0);
    send_word(KIND_ACC,  GT_HOM_MAJOR, 12'd2,    6'd1,  1'b0);
    send_word(KIND_ACC,  GT_MISSING,   12'd1,    6'd2,  1'b0);
    send_word(KIND_ACC,  GT_HOM_MINOR, 12'd2,    6'd3,  1'b0);
    send_word(KIND_ACC,  GT_HOM_MINOR, 12'd4095, 6'd63, 1'b1);
    drain();
  endtask

  // Walk the register through zero, its limit and beyond.
  task automatic test_count_extremes();
    logic [6:0] settings [4];
    settings = '{7'd0, 7'd127, 7'd64, 7'd65};
    foreach (settings[s]) begin
      write_population_count(settings[s]);
      send_word(KIND_ACC, GT_HET,       12'd1,    6'd0,  1'b0);
      send_word(KIND_ACC, GT_HOM_MINOR, 12'd2048, 6'd63, 1'b1);
      drain();
    end
  endtask

  // Pile diploid calls onto population 0; population 1 takes noise.
  task automatic test_saturation();
    write_population_count(7'd2);
    send_word(KIND_SCAN, GT_HET, 12'd7, 6'd0, 1'b0);
    for (int i = 0; i < SAT_WORDS; i++) begin
      send_word(KIND_ACC, GT_HOM_MINOR, 12'd7, 6'd0, 1'b0);
      if (i % 4 == 0)
        send_word(KIND_ACC, 2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                  6'd1, 1'b0);
    end
    send_word(KIND_ACC, GT_HOM_MINOR, 12'd7, 6'd0, 1'b1);
    drain();
  endtask

  // Random sites: mostly scan and accumulate words for counted populations,
  // some stray populations, a few scans carrying a site end.
  task automatic test_random_sites();
    int unsigned sent;
    int unsigned site_len;
    logic [11:0] ind;
    logic [5:0]  pop;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_population_count(7'($urandom_range(0, 127)));
      end
      quiet = ($urandom_range(0, 3) == 0);
      site_len = $urandom_range(0, 12);
      for (int j = 0; j <= site_len; j++) begin
        ind = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                          : 12'($urandom_range(0, 15));
        pop = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, emitted_populations() - 1));
        if (j == site_len)
          send_word(KIND_ACC, 2'($urandom_range(0, 3)), ind, pop, 1'b1);
        else if ($urandom_range(0, 3) == 0)
          send_word(KIND_SCAN, 2'($urandom_range(0, 3)), ind, pop,
                    1'($urandom_range(0, 1)));
        else
          send_word(KIND_ACC, 2'($urandom_range(0, 3)), ind, pop, 1'b0);
      end
      sent += site_len + 1;
    end
    quiet = 1'b0;
  endtask

  // Stall the result side in random bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (!quiet && $urandom_range(0, 4) == 0) stall_left <= pick_gap();
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    freq_word_t got;
    freq_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{population_o, frequency_o, present_o, allele_count_o, last_o};
      if (pending_freqs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected word: pop=%0d freq=%0d present=%0b count=%0d last=%0b",
                   got.population, got.frequency, got.present, got.allele_count,
                   got.last);
      end else begin
        want = pending_freqs.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: exp pop=%0d freq=%0d present=%0b count=%0d last=%0b, %s",
                     want.population, want.frequency, want.present, want.allele_count,
                     want.last, $sformatf("got pop=%0d freq=%0d present=%0b count=%0d last=%0b",
                     got.population, got.frequency, got.present, got.allele_count,
                     got.last));
        end
      end
    end
  end

  // Bound the run.
  initial begin
    #100_000_000;
    $display("** genotype_group_allele_freq: FAILED **");
    $finish;
  end

  initial begin
    rst_ni                 = 1'b0;
    cfg_valid_i            = 1'b0;
    cfg_population_count_i = '0;
    in_valid_i             = 1'b0;
    kind_i                 = KIND_SCAN;
    genotype_code_i        = GT_MISSING;
    individual_index_i     = '0;
    population_index_i     = '0;
    last_of_site_i         = 1'b0;
    out_stall_i            = 1'b0;
    stall_left             = 0;
    quiet                  = 1'b0;
    mismatches             = 0;
    pop_count_reg          = 7'd1;
    foreach (ploidy_flag[i]) ploidy_flag[i] = 1'b0;
    foreach (dosage_half[p]) begin
      dosage_half[p] = '0;
      calls_half[p]  = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_count();
    test_codes_ploidy();
    test_count_extremes();
    test_saturation();
    test_random_sites();
    drain();

    if (mismatches == 0) begin
      $display("** genotype_group_allele_freq: PASSED **");
    end else begin
      $display("** genotype_group_allele_freq: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ggaf_pkg.sv
hw/rtl/genotype_group_allele_freq.sv
verif/tb.sv
